/* design/met_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Mandelbrot escape-time pixel block.
// Used by every module of the block; depends on nothing else.

package met_pkg;

  // Default geometry and arithmetic settings.
  localparam int WIDTH_DEF     = 320;
  localparam int HEIGHT_DEF    = 240;
  localparam int ITER_CAP_DEF  = 256;
  localparam int FRAC_BITS_DEF = 28;

  // Field widths.
  localparam int PIX_W     = 10;
  localparam int COORD_W   = 32;
  localparam int STEP_W    = 31;
  localparam int CHAN_W    = 8;
  localparam int ITER_W    = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Setup multiplier operand and product widths (sized for FRAC_BITS up to 28).
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SAT_W  = PROD_W + 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_RE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_IM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_ROTATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_HUE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 3'd5;

  // Register values after reset.
  localparam logic signed [COORD_W-1:0] CENTER_RE_RST  = -32'sd161061274;
  localparam logic signed [COORD_W-1:0] CENTER_IM_RST  = 32'sd0;
  localparam logic [STEP_W-1:0]         PIXEL_STEP_RST = 31'd2097152;
  localparam logic                      HUE_ROTATE_RST = 1'b0;
  localparam logic                      INVERT_HUE_RST = 1'b0;
  localparam logic                      COLOR_MODE_RST = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] column;
    logic [PIX_W-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [ITER_W-1:0] iterations;
    logic              escaped;
  } out_item_t;

  typedef struct packed {
    logic done;
    logic in_set;
  } setup_stat_t;

  typedef struct packed {
    logic              done;
    logic              escaped;
    logic [ITER_W-1:0] count;
  } iter_stat_t;

  // Clamp a wide signed value into the signed 32-bit range.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(32'sh7FFFFFFF);
    lo = SAT_W'(32'sh80000000);
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

/* design/mandelbrot_escape_time_pixel.sv */
`timescale 1ns / 1ps
// Top level of the Mandelbrot escape-time pixel block: handshakes, configuration, sequencing.
// Depends on met_pkg, met_setup, met_iter and met_palette.

// This block colours one pixel of a Mandelbrot view per item. An input item carries a
// column and a row; the block centres them on the screen (subtracting half of WIDTH and
// HEIGHT), scales by pixel_step and adds the view centre to get the point c in signed
// fixed point with FRAC_BITS fraction bits, saturated to 32 bits. Points inside the main
// cardioid or the period-2 bulb are reported black with zero iterations and no iteration
// work. Every other point runs z = z^2 + c until |z|^2 reaches 4 or ITER_CAP steps are
// done; escaped points are coloured from the count, either through a six-sector HSV wheel
// (with optional hue inversion and a one-sector rotation) or as a grayscale ramp, and
// points that never escape are black. One item is processed at a time and the input side
// stalls while it is at work: setup runs on a single shared multiplier, then the
// complex-square unit does one iteration per cycle. The finished item sits in an output
// register, and the next item can start while that result waits for the receiver.
// Configuration is written through a separate port that is always ready and must only be
// used while the block is idle.

module mandelbrot_escape_time_pixel import met_pkg::*; #(
  parameter int WIDTH     = WIDTH_DEF,
  parameter int HEIGHT    = HEIGHT_DEF,
  parameter int ITER_CAP  = ITER_CAP_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_ITER  = 4'b0100,
    S_EMIT  = 4'b1000
  } top_state_t;

  top_state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [COORD_W-1:0] center_re_r, center_im_r;
  logic [STEP_W-1:0]         pixel_step_r;
  logic                      hue_rotate_r, invert_hue_r, color_mode_r;

  in_item_t          item_r;
  logic [ITER_W-1:0] res_iter_r;
  logic              res_esc_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic                      in_acc, slot_free, iter_start;
  logic                      cfg_we;
  logic signed [COORD_W-1:0] pt_x, pt_y;
  setup_stat_t               setup_stat;
  iter_stat_t                iter_stat;
  logic [CHAN_W-1:0]         pal_red, pal_green, pal_blue;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_re_r  <= CENTER_RE_RST;
      center_im_r  <= CENTER_IM_RST;
      pixel_step_r <= PIXEL_STEP_RST;
      hue_rotate_r <= HUE_ROTATE_RST;
      invert_hue_r <= INVERT_HUE_RST;
      color_mode_r <= COLOR_MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_RE:  center_re_r  <= $signed(cfg_data);
        REG_CENTER_IM:  center_im_r  <= $signed(cfg_data);
        REG_PIXEL_STEP: pixel_step_r <= cfg_data[STEP_W-1:0];
        REG_HUE_ROTATE: hue_rotate_r <= cfg_data[0];
        REG_INVERT_HUE: invert_hue_r <= cfg_data[0];
        REG_COLOR_MODE: color_mode_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  met_setup #(
    .WIDTH     (WIDTH),
    .HEIGHT    (HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_setup (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc),
    .column     (item_r.column),
    .row        (item_r.row),
    .center_re  (center_re_r),
    .center_im  (center_im_r),
    .pixel_step (pixel_step_r),
    .x          (pt_x),
    .y          (pt_y),
    .stat       (setup_stat)
  );

  met_iter #(
    .ITER_CAP  (ITER_CAP),
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .start (iter_start),
    .x     (pt_x),
    .y     (pt_y),
    .stat  (iter_stat)
  );

  met_palette u_palette (
    .iterations (res_iter_r),
    .escaped    (res_esc_r),
    .hue_rotate (hue_rotate_r),
    .invert_hue (invert_hue_r),
    .color_mode (color_mode_r),
    .red        (pal_red),
    .green      (pal_green),
    .blue       (pal_blue)
  );

  // Sequencer: setup, then iterate unless the point is known to be inside the set,
  // then hand the colour to the output register once it is free.
  always_comb begin
    state_nxt  = state_r;
    iter_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (setup_stat.done) begin
          if (setup_stat.in_set) begin
            state_nxt = S_EMIT;
          end else begin
            iter_start = 1'b1;
            state_nxt  = S_ITER;
          end
        end
      end
      S_ITER: begin
        if (iter_stat.done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item and result holding registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    if (state_r == S_SETUP && setup_stat.done && setup_stat.in_set) begin
      res_iter_r <= '0;
      res_esc_r  <= 1'b0;
    end else if (state_r == S_ITER && iter_stat.done) begin
      res_iter_r <= iter_stat.count;
      res_esc_r  <= iter_stat.escaped;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && slot_free) begin
      out_data_r.red        <= pal_red;
      out_data_r.green      <= pal_green;
      out_data_r.blue       <= pal_blue;
      out_data_r.iterations <= res_iter_r;
      out_data_r.escaped    <= res_esc_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/met_setup.sv */
`timescale 1ns / 1ps
// Pixel-to-plane mapping and cardioid / period-2 bulb test on one shared multiplier.
// Depends on met_pkg.

module met_setup import met_pkg::*; #(
  parameter int WIDTH     = WIDTH_DEF,
  parameter int HEIGHT    = HEIGHT_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [PIX_W-1:0]          column,
  input  logic [PIX_W-1:0]          row,
  input  logic signed [COORD_W-1:0] center_re,
  input  logic signed [COORD_W-1:0] center_im,
  input  logic [STEP_W-1:0]         pixel_step,
  output logic signed [COORD_W-1:0] x,
  output logic signed [COORD_W-1:0] y,
  output setup_stat_t               stat
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_COL  = 9'b000000010,
    ST_ROW  = 9'b000000100,
    ST_AA   = 9'b000001000,
    ST_YY   = 9'b000010000,
    ST_PP   = 9'b000100000,
    ST_QT   = 9'b001000000,
    ST_CQ   = 9'b010000000,
    ST_FIN  = 9'b100000000
  } setup_state_t;

  localparam logic signed [MUL_W-1:0]   ONE      = MUL_W'(1) <<< FRAC_BITS;
  localparam logic signed [MUL_W-1:0]   QUARTER  = MUL_W'(1) <<< (FRAC_BITS - 2);
  localparam logic signed [COORD_W:0]   TWO      = (COORD_W + 1)'(1) <<< (FRAC_BITS + 1);
  localparam logic signed [SUM_W-1:0]   BULB_LIM = SUM_W'(1) <<< (2 * FRAC_BITS - 4);
  localparam logic signed [PIX_W:0]     HALF_W   = (PIX_W + 1)'(WIDTH / 2);
  localparam logic signed [PIX_W:0]     HALF_H   = (PIX_W + 1)'(HEIGHT / 2);

  setup_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] x_r, y_r;
  logic signed [PROD_W-1:0]  prod_r, acc_r, yy_r;
  logic signed [MUL_W-1:0]   q_r, t_r;
  logic                      bulb_r;

  logic signed [MUL_W-1:0]   opa, opb;
  logic signed [PIX_W:0]     dcol, drow;
  logic signed [MUL_W-1:0]   a_val, p_val;
  logic signed [SUM_W-1:0]   qsum;
  logic signed [COORD_W:0]   xe, ye;
  logic                      in_range, cardioid;

  assign dcol  = $signed({1'b0, column}) - HALF_W;
  assign drow  = $signed({1'b0, row}) - HALF_H;
  assign a_val = MUL_W'(x_r) - QUARTER;
  assign p_val = MUL_W'(x_r) + ONE;
  assign qsum  = SUM_W'(acc_r) + SUM_W'(prod_r);
  assign xe    = (COORD_W + 1)'(x_r);
  assign ye    = (COORD_W + 1)'(y_r);

  assign in_range = (xe > -TWO) && (xe < TWO) && (ye > -TWO) && (ye < TWO);
  assign cardioid = prod_r < (yy_r >>> 2);

  always_comb begin
    state_nxt = state_r;
    opa       = '0;
    opb       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_COL;
        end
      end
      ST_COL: begin
        opa       = MUL_W'(dcol);
        opb       = $signed({2'b00, pixel_step});
        state_nxt = ST_ROW;
      end
      ST_ROW: begin
        opa       = MUL_W'(drow);
        opb       = $signed({2'b00, pixel_step});
        state_nxt = ST_AA;
      end
      ST_AA: begin
        opa       = a_val;
        opb       = a_val;
        state_nxt = ST_YY;
      end
      ST_YY: begin
        opa       = MUL_W'(y_r);
        opb       = MUL_W'(y_r);
        state_nxt = ST_PP;
      end
      ST_PP: begin
        opa       = p_val;
        opb       = p_val;
        state_nxt = ST_QT;
      end
      ST_QT: begin
        state_nxt = ST_CQ;
      end
      ST_CQ: begin
        opa       = q_r;
        opb       = t_r;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    case (state_r)
      ST_ROW: begin
        x_r <= sat32(SAT_W'(prod_r) + SAT_W'(center_re));
      end
      ST_AA: begin
        y_r <= sat32(SAT_W'(prod_r) + SAT_W'(center_im));
      end
      ST_YY: begin
        acc_r <= prod_r;
      end
      ST_PP: begin
        yy_r <= prod_r;
        q_r  <= MUL_W'(qsum >>> FRAC_BITS);
      end
      ST_QT: begin
        bulb_r <= (SUM_W'(prod_r) + SUM_W'(yy_r)) < BULB_LIM;
        t_r    <= q_r + a_val;
      end
      default: begin
      end
    endcase
  end

  assign x           = x_r;
  assign y           = y_r;
  assign stat.done   = (state_r == ST_FIN);
  assign stat.in_set = in_range && (cardioid || bulb_r);

endmodule

/* design/met_iter.sv */
`timescale 1ns / 1ps
// Complex-square iteration unit: one z = z^2 + c step per cycle with escape test.
// Depends on met_pkg.

module met_iter import met_pkg::*; #(
  parameter int ITER_CAP  = ITER_CAP_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] x,
  input  logic signed [COORD_W-1:0] y,
  output iter_stat_t                stat
);

  localparam int CNT_W = $clog2(ITER_CAP + 1);
  localparam int SQ_W  = 65 - FRAC_BITS;
  localparam int NW    = SQ_W + 1;
  localparam logic [SQ_W-1:0]  FOUR    = SQ_W'(1) << (FRAC_BITS + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ITER_CAP);

  logic                      busy_r;
  logic signed [COORD_W-1:0] zx_r, zy_r;
  logic [CNT_W-1:0]          iter_r;

  logic signed [2*COORD_W-1:0] pxx, pyy, pxy;
  logic [63-FRAC_BITS:0]       zx2, zy2;
  logic [SQ_W-1:0]             mag;
  logic signed [NW-1:0]        nzx, nzy;
  logic                        limit_hit, finish;

  // The squares are never negative, so the floor shift is a plain slice.
  assign pxx = zx_r * zx_r;
  assign pyy = zy_r * zy_r;
  assign pxy = zx_r * zy_r;
  assign zx2 = pxx[2*COORD_W-1:FRAC_BITS];
  assign zy2 = pyy[2*COORD_W-1:FRAC_BITS];
  assign mag = {1'b0, zx2} + {1'b0, zy2};

  assign nzx = $signed({2'b00, zx2}) - $signed({2'b00, zy2}) + NW'(x);
  assign nzy = NW'(pxy >>> (FRAC_BITS - 1)) + NW'(y);

  assign limit_hit = (iter_r == CNT_MAX);
  assign finish    = busy_r && (limit_hit || (mag >= FOUR));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (finish) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zx_r   <= '0;
      zy_r   <= '0;
      iter_r <= '0;
    end else if (busy_r && !finish) begin
      zx_r   <= sat32(SAT_W'(nzx));
      zy_r   <= sat32(SAT_W'(nzy));
      iter_r <= iter_r + CNT_W'(1);
    end
  end

  assign stat.done    = finish;
  assign stat.escaped = !limit_hit;
  assign stat.count   = ITER_W'(iter_r);

endmodule

/* design/met_palette.sv */
`timescale 1ns / 1ps
// Iteration count to RGB colour: fixed-point HSV wheel or grayscale ramp.
// Depends on met_pkg.

module met_palette import met_pkg::*; (
  input  logic [ITER_W-1:0] iterations,
  input  logic              escaped,
  input  logic              hue_rotate,
  input  logic              invert_hue,
  input  logic              color_mode,
  output logic [CHAN_W-1:0] red,
  output logic [CHAN_W-1:0] green,
  output logic [CHAN_W-1:0] blue
);

  localparam logic [2:0] SEC_RY = 3'd0;
  localparam logic [2:0] SEC_YG = 3'd1;
  localparam logic [2:0] SEC_GC = 3'd2;
  localparam logic [2:0] SEC_CB = 3'd3;
  localparam logic [2:0] SEC_BM = 3'd4;
  localparam logic [2:0] SEC_MR = 3'd5;

  localparam logic [CHAN_W-1:0] FULL = 8'd255;

  logic [CHAN_W-1:0] h;
  logic [9:0]        h4;
  logic [2:0]        corr;
  logic [18:0]       hue;
  logic [2:0]        sector;
  logic [16:0]       frac, hue_dev, level;
  logic [24:0]       scaled;
  logic [CHAN_W-1:0] xv;

  assign h  = invert_hue ? (FULL - iterations[CHAN_W-1:0]) : iterations[CHAN_W-1:0];
  assign h4 = {h, 2'b00};

  // 262144 / 255 = 1028 remainder 4, so the quotient is 1028*h plus floor(4h / 255).
  assign corr = 3'({2'b00, h4 >= 10'd255}) + 3'({2'b00, h4 >= 10'd510})
              + 3'({2'b00, h4 >= 10'd765}) + 3'({2'b00, h4 >= 10'd1020});

  // The hue never reaches 6.0, so no wrap is needed.
  assign hue = (19'(h) << 10) + (19'(h) << 2) + 19'(corr) + 19'd7
             + (hue_rotate ? 19'd65536 : 19'd0);

  assign sector  = hue[18:16];
  assign frac    = hue[16:0];
  assign hue_dev = frac[16] ? {1'b0, frac[15:0]} : (17'd65536 - frac);
  assign level   = 17'd65536 - hue_dev;
  assign scaled  = {level, 8'b0} - 25'(level);
  assign xv      = scaled[23:16];

  always_comb begin
    red   = '0;
    green = '0;
    blue  = '0;
    if (escaped) begin
      if (!color_mode) begin
        red   = FULL - h;
        green = FULL - h;
        blue  = FULL - h;
      end else begin
        case (sector)
          SEC_RY: begin
            red   = FULL;
            green = xv;
          end
          SEC_YG: begin
            red   = xv;
            green = FULL;
          end
          SEC_GC: begin
            green = FULL;
            blue  = xv;
          end
          SEC_CB: begin
            green = xv;
            blue  = FULL;
          end
          SEC_BM: begin
            red  = xv;
            blue = FULL;
          end
          SEC_MR: begin
            red  = FULL;
            blue = xv;
          end
          default: begin
            red  = FULL;
            blue = xv;
          end
        endcase
      end
    end
  end

endmodule
